/* hw/rtl/time_window_range_average_unit_assert.svh */
// assertion macros shared by the time window range/average rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef TIME_WINDOW_RANGE_AVERAGE_UNIT_ASSERT_SVH
`define TIME_WINDOW_RANGE_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TWRA_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define TWRA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/twra_pkg.sv */
// shared constants, types and helpers of the time window range/average unit
// no dependencies
`timescale 1ns / 1ps

package twra_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int TIME_W       = 32;
    localparam int VALUE_W      = 16;
    localparam int SUM_W        = VALUE_W + IDX_W;
    localparam int ENTRY_W      = TIME_W + VALUE_W;
    localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
    localparam int APB_ADDR_W   = 2;
    localparam int APB_DATA_W   = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LENGTH = '0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OVF_RD,
        ST_OVF_UPD,
        ST_WRITE,
        ST_TRIM_RD,
        ST_TRIM_CHK,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_range;
        logic [VALUE_W-1:0] value_average;
        logic [TIME_W-1:0]  window_span;
        logic [CNT_W-1:0]   sample_count;
        logic               overflow;
    } result_t;

    // circular slot arithmetic, base and offset both below the depth
    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                    input logic [CNT_W-1:0] offset);
        logic [IDX_W:0] s;
        s = (IDX_W+1)'(base) + (IDX_W+1)'(offset);
        if (s >= (IDX_W+1)'(WINDOW_DEPTH)) begin
            s = s - (IDX_W+1)'(WINDOW_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

/* hw/rtl/twra_ram.sv */
// generic single-port synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module twra_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

/* hw/rtl/twra_div.sv */
// restoring divider for the window mean, one quotient bit per cycle
// depends on twra_pkg
`timescale 1ns / 1ps

module twra_div
    import twra_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     den_reg, den_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/twra_core.sv */
// window sequencer: sample store, eviction, min/max scan and mean
// depends on twra_pkg, twra_ram, twra_div and the assertion macro header
`timescale 1ns / 1ps
`include "time_window_range_average_unit_assert.svh"

module twra_core
    import twra_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TIME_W-1:0]  window_length,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [TIME_W-1:0]  in_time,
    input  logic [VALUE_W-1:0] in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  t_reg, t_next;
    logic [VALUE_W-1:0] v_reg, v_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [TIME_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic               first_reg, first_next;
    logic               div_go_reg, div_go_next;
    logic [VALUE_W-1:0] lo_reg, lo_next;
    logic [VALUE_W-1:0] hi_reg, hi_next;
    logic [TIME_W-1:0]  t_old_reg, t_old_next;
    logic [TIME_W-1:0]  t_new_reg, t_new_next;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [TIME_W-1:0]  r_time;
    logic [VALUE_W-1:0] r_value;

    logic               trim_now;
    logic               drop_ok;
    logic               scan_go;
    logic               scan_end;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;

    twra_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .re   (ram_re),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    twra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .dividend(sum_reg),
        .divisor (held_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign r_time  = ram_rdata[ENTRY_W-1 -: TIME_W];
    assign r_value = ram_rdata[VALUE_W-1:0];

    assign trim_now = (window_length != '0) && (t_reg >= window_length);
    assign drop_ok  = r_time < thr_reg;
    assign scan_go  = (state_reg == ST_WRITE && !trim_now)
                   || (state_reg == ST_TRIM_RD && held_reg <= CNT_W'(1))
                   || (state_reg == ST_TRIM_CHK && !drop_ok);
    assign scan_end = (issue_reg == held_reg) && !pend_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (held_reg == CNT_W'(WINDOW_DEPTH)) ? ST_OVF_RD : ST_WRITE;
                end
            end
            ST_OVF_RD:   state_next = ST_OVF_UPD;
            ST_OVF_UPD:  state_next = ST_WRITE;
            ST_WRITE:    state_next = trim_now ? ST_TRIM_RD : ST_SCAN;
            ST_TRIM_RD:  state_next = (held_reg > CNT_W'(1)) ? ST_TRIM_CHK : ST_SCAN;
            ST_TRIM_CHK: state_next = drop_ok ? ST_TRIM_RD : ST_SCAN;
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        t_next      = t_reg;
        v_next      = v_reg;
        ovf_next    = ovf_reg;
        oldest_next = oldest_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        thr_next    = thr_reg;
        issue_next  = issue_reg;
        pend_next   = 1'b0;
        first_next  = first_reg;
        div_go_next = 1'b0;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        t_old_next  = t_old_reg;
        t_new_next  = t_new_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = oldest_reg;
        ram_wdata   = {t_reg, v_reg};
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                t_next   = in_time;
                v_next   = in_value;
                ovf_next = 1'b0;
            end
            ST_OVF_RD: begin
                ram_re = 1'b1;
            end
            ST_OVF_UPD: begin
                sum_next    = sum_reg - SUM_W'(r_value);
                oldest_next = slot_after(oldest_reg, CNT_W'(1));
                held_next   = held_reg - CNT_W'(1);
                ovf_next    = 1'b1;
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                ram_addr  = slot_after(oldest_reg, held_reg);
                held_next = held_reg + CNT_W'(1);
                sum_next  = sum_reg + SUM_W'(v_reg);
                thr_next  = t_reg - window_length;
            end
            ST_TRIM_RD: begin
                ram_re = held_reg > CNT_W'(1);
            end
            ST_TRIM_CHK: begin
                if (drop_ok) begin
                    sum_next    = sum_reg - SUM_W'(r_value);
                    oldest_next = slot_after(oldest_reg, CNT_W'(1));
                    held_next   = held_reg - CNT_W'(1);
                end
            end
            ST_SCAN: begin
                if (issue_reg != held_reg) begin
                    ram_re     = 1'b1;
                    ram_addr   = slot_after(oldest_reg, issue_reg);
                    issue_next = issue_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end
                // read data of the previous cycle's address
                if (pend_reg) begin
                    t_new_next = r_time;
                    first_next = 1'b0;
                    if (first_reg) begin
                        lo_next    = r_value;
                        hi_next    = r_value;
                        t_old_next = r_time;
                    end else begin
                        if (r_value < lo_reg) begin
                            lo_next = r_value;
                        end
                        if (r_value > hi_reg) begin
                            hi_next = r_value;
                        end
                    end
                end
            end
            ST_WAIT: begin
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase

        if (scan_go) begin
            issue_next  = '0;
            first_next  = 1'b1;
            div_go_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            held_reg   <= '0;
            sum_reg    <= '0;
            pend_reg   <= 1'b0;
            div_go_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
            sum_reg    <= sum_next;
            pend_reg   <= pend_next;
            div_go_reg <= div_go_next;
        end
        t_reg     <= t_next;
        v_reg     <= v_next;
        ovf_reg   <= ovf_next;
        thr_reg   <= thr_next;
        issue_reg <= issue_next;
        first_reg <= first_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        t_old_reg <= t_old_next;
        t_new_reg <= t_new_next;
    end

    assign res.value_range   = hi_reg - lo_reg;
    assign res.value_average = div_quo[VALUE_W-1:0];
    assign res.window_span   = t_new_reg - t_old_reg;
    assign res.sample_count  = held_reg;
    assign res.overflow      = ovf_reg;

    `TWRA_ASSERT_NOW(a_held_bound, aclk, aresetn, 1'b1, held_reg <= CNT_W'(WINDOW_DEPTH), "held count above depth")
    `TWRA_ASSERT_NOW(a_result_nonempty, aclk, aresetn, res_valid, held_reg != '0, "result with empty window")
    `TWRA_ASSERT_NEXT(a_accept_path, aclk, aresetn, in_valid && in_ready, state_reg == ST_WRITE || state_reg == ST_OVF_RD, "accepted transaction not stored")
    `TWRA_ASSERT_NEXT(a_ovf_room, aclk, aresetn, state_reg == ST_OVF_UPD, held_reg == CNT_W'(WINDOW_DEPTH - 1), "overflow drop left wrong count")

endmodule

/* hw/rtl/time_window_range_average_unit.sv */
// flow: a sample taken in idle is written to the store, first dropping the oldest if the store is
// full; with window_length nonzero and the sample time at least window_length, samples older
// than time - window_length are then dropped from the oldest end while more than one is held;
// the held samples are then walked for min/max while the 22-step divider forms the mean
// one transaction at a time: the next is taken once the result moves to the output register
// reset (aresetn, synchronous) empties the window and clears window_length; store not cleared
`timescale 1ns / 1ps

module time_window_range_average_unit
    import twra_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_W-1:0]     s_sample_time,
    input  logic [VALUE_W-1:0]    s_sample_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_W-1:0]    m_value_range,
    output logic [VALUE_W-1:0]    m_value_average,
    output logic [TIME_W-1:0]     m_window_span,
    output logic [CNT_W-1:0]      m_sample_count,
    output logic                  m_overflow
);

    logic [TIME_W-1:0] wl_reg, wl_next;
    logic              m_valid_reg, m_valid_next;
    result_t           out_reg, out_next;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    twra_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .window_length(wl_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_time      (s_sample_time),
        .in_value     (s_sample_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? APB_DATA_W'(wl_reg) : '0;

    always_comb begin
        wl_next = wl_reg;
        if (psel && penable && pwrite && paddr == ADDR_WINDOW_LENGTH) begin
            wl_next = pwdata[TIME_W-1:0];
        end
    end

    // output register frees when empty or when its transaction is taken
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wl_reg      <= wl_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_value_range   = out_reg.value_range;
    assign m_value_average = out_reg.value_average;
    assign m_window_span   = out_reg.window_span;
    assign m_sample_count  = out_reg.sample_count;
    assign m_overflow      = out_reg.overflow;

endmodule
